// ----- hw/rtl/http_chunked_body_decoder_top_defines.svh -----
// Assertion macros for the chunked body decoder.
// Used by http_chunked_body_decoder_top; no other dependencies.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define HCBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hcbd assertion failed");

// next-cycle implication
`define HCBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hcbd assertion failed");

`endif

// ----- hw/rtl/hcbd_pkg.sv -----
// Types and constants for the HTTP chunked body decoder.
// No dependencies; used by hcbd_step and http_chunked_body_decoder_top.
package hcbd_pkg;

	typedef enum logic [2:0] {
		PH_SIZE    = 3'd0,
		PH_DATA    = 3'd1,
		PH_CR      = 3'd2,
		PH_LF      = 3'd3,
		PH_TRAILER = 3'd4,
		PH_DONE    = 3'd5,
		PH_ERROR   = 3'd6
	} hcbd_phase_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_END   = 2'd1,
		KIND_ERROR = 2'd2
	} hcbd_kind_t;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_SP  = 8'h20;

	typedef struct packed {
		logic       body_start;
		logic [7:0] in_byte;
	} hcbd_in_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_byte;
	} hcbd_out_t;

	// parser flags, everything but the size counter
	typedef struct packed {
		hcbd_phase_t phase;
		logic        prev_was_cr;
		logic        line_has_content;
		logic        digits_seen;
		logic        digits_ended;
	} hcbd_flags_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hcbd_hex_t;

	function automatic hcbd_hex_t hex_decode(input logic [7:0] c);
		hcbd_hex_t h;
		h.valid = 1'b1;
		h.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.value = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.value = 4'(c - 8'h37);
		end else begin
			h.valid = 1'b0;
		end
		return h;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF;
	endfunction

endpackage

// ----- hw/rtl/hcbd_step.sv -----
// Next-state and result logic for one byte of a chunked body.
// Depends on hcbd_pkg.
module hcbd_step #(
	parameter int SIZE_BITS = 32
) (
	input  hcbd_pkg::hcbd_flags_t flags,
	input  logic [SIZE_BITS-1:0]  remaining,
	input  hcbd_pkg::hcbd_in_t    item,
	output hcbd_pkg::hcbd_flags_t flags_next,
	output logic [SIZE_BITS-1:0]  remaining_next,
	output logic                  has_result,
	output hcbd_pkg::hcbd_out_t   result
);
	import hcbd_pkg::*;

	hcbd_flags_t          cur;
	logic [SIZE_BITS-1:0] rem;
	logic [7:0]           c;
	hcbd_hex_t            hex;

	assign c   = item.in_byte;
	assign hex = hex_decode(c);

	always_comb begin
		cur = flags;
		rem = remaining;
		if (item.body_start) begin
			cur.phase            = PH_SIZE;
			cur.prev_was_cr      = 1'b0;
			cur.line_has_content = 1'b0;
			cur.digits_seen      = 1'b0;
			cur.digits_ended     = 1'b0;
			rem                  = '0;
		end

		flags_next     = cur;
		remaining_next = rem;
		has_result     = 1'b0;
		result         = '0;

		case (cur.phase)
			PH_SIZE: begin
				if (c == CH_LF && cur.prev_was_cr) begin
					if (!cur.line_has_content || !cur.digits_seen) begin
						flags_next.phase = PH_ERROR;
						has_result       = 1'b1;
						result.out_kind  = KIND_ERROR;
					end else begin
						flags_next.line_has_content = 1'b0;
						flags_next.digits_seen      = 1'b0;
						flags_next.digits_ended     = 1'b0;
						flags_next.prev_was_cr      = 1'b0;
						flags_next.phase = (rem == '0) ? PH_TRAILER : PH_DATA;
					end
				end else begin
					flags_next.prev_was_cr = (c == CH_CR);
					if (c != CH_CR) begin
						flags_next.line_has_content = 1'b1;
						if (!cur.digits_ended) begin
							if (hex.valid) begin
								// another digit would shift bits off the top
								if (rem[SIZE_BITS-1 -: 4] != 4'd0) begin
									flags_next.phase = PH_ERROR;
									has_result       = 1'b1;
									result.out_kind  = KIND_ERROR;
								end else begin
									remaining_next          = {rem[SIZE_BITS-5:0], hex.value};
									flags_next.digits_seen  = 1'b1;
								end
							end else if (cur.digits_seen || !is_blank(c)) begin
								flags_next.digits_ended = 1'b1;
							end
						end
					end
				end
			end
			PH_DATA: begin
				remaining_next  = rem - SIZE_BITS'(1);
				if (rem == SIZE_BITS'(1)) begin
					flags_next.phase = PH_CR;
				end
				has_result      = 1'b1;
				result.out_kind = KIND_DATA;
				result.out_byte = c;
			end
			PH_CR: begin
				flags_next.prev_was_cr = (c == CH_CR);
				flags_next.phase       = PH_LF;
			end
			PH_LF: begin
				if (c != CH_LF || !cur.prev_was_cr) begin
					flags_next.phase = PH_ERROR;
					has_result       = 1'b1;
					result.out_kind  = KIND_ERROR;
				end else begin
					remaining_next              = '0;
					flags_next.line_has_content = 1'b0;
					flags_next.digits_seen      = 1'b0;
					flags_next.digits_ended     = 1'b0;
					// closing CR counts as previous byte of the next size line
					flags_next.prev_was_cr      = 1'b1;
					flags_next.phase            = PH_SIZE;
				end
			end
			PH_TRAILER: begin
				if (c == CH_LF) begin
					if (!cur.line_has_content) begin
						flags_next.phase = PH_DONE;
						has_result       = 1'b1;
						result.out_kind  = KIND_END;
					end else begin
						flags_next.line_has_content = 1'b0;
					end
				end else if (c != CH_SP && c != CH_TAB && c != CH_CR) begin
					flags_next.line_has_content = 1'b1;
				end
			end
			default: begin
				// done or error: absorb bytes until a new body starts
			end
		endcase
	end

endmodule

// ----- hw/rtl/http_chunked_body_decoder_top.sv -----
// HTTP chunked transfer-coding body decoder, top level.
// Depends on hcbd_pkg, hcbd_step and http_chunked_body_decoder_top_defines.svh.
//
//  channel | dir | handshake                   | payload
//  item    | in  | item_valid / item_ready     | hcbd_in_t  {body_start, in_byte}
//  result  | out | result_valid / result_ready | hcbd_out_t {out_kind, out_byte}
//
// One byte per cycle sustained while the output register is free. A byte is
// registered in the input stage, decoded there by hcbd_step, and its result
// (if any) is registered in the output register, which drives result_valid.
// arst_n clears the parser state, the input stage valid and the output valid.
// A byte with no result moves on even while the output register is held;
// a byte with a result waits in the input stage until the output frees up.
module http_chunked_body_decoder_top #(
	parameter int SIZE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  hcbd_pkg::hcbd_in_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output hcbd_pkg::hcbd_out_t result
);
	import hcbd_pkg::*;

	`include "http_chunked_body_decoder_top_defines.svh"

	logic                 valid_s1;
	hcbd_in_t             item_s1;
	hcbd_flags_t          flags_q;
	logic [SIZE_BITS-1:0] remaining_q;
	logic                 result_valid_q;
	hcbd_out_t            result_q;

	hcbd_flags_t          flags_d;
	logic [SIZE_BITS-1:0] remaining_d;
	logic                 has_result;
	hcbd_out_t            step_result;
	logic                 out_free;
	logic                 advance;
	logic                 ctrl_out;

	hcbd_step #(
		.SIZE_BITS(SIZE_BITS)
	) u_step (
		.flags          (flags_q),
		.remaining      (remaining_q),
		.item           (item_s1),
		.flags_next     (flags_d),
		.remaining_next (remaining_d),
		.has_result     (has_result),
		.result         (step_result)
	);

	assign out_free     = !result_valid_q || result_ready;
	assign advance      = valid_s1 && (out_free || !has_result);
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign ctrl_out     = result_valid && result.out_kind != KIND_DATA;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q.phase            <= PH_SIZE;
			flags_q.prev_was_cr      <= 1'b0;
			flags_q.line_has_content <= 1'b0;
			flags_q.digits_seen      <= 1'b0;
			flags_q.digits_ended     <= 1'b0;
			remaining_q              <= '0;
		end else if (advance) begin
			flags_q     <= flags_d;
			remaining_q <= remaining_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= advance && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_q <= step_result;
		end
	end

	// a blocked byte stays put in the input stage
	`HCBD_ASSERT_NXT(a_stall_holds, clk, arst_n, !item_ready, valid_s1 && $stable(item_s1))
	// only data results carry a byte
	`HCBD_ASSERT_IMP(a_ctrl_zero, clk, arst_n, ctrl_out, result.out_byte == 8'd0)
	// data phase always has bytes left to pass
	`HCBD_ASSERT_IMP(a_data_left, clk, arst_n, flags_q.phase == PH_DATA, remaining_q != '0)

endmodule

// ----- dv/tb_http_chunked_body_decoder_top.sv -----
// Testbench for http_chunked_body_decoder_top: drives directed and random chunked
// bodies, predicts every result in step with the driver and checks them in order.
// Depends on hcbd_pkg and the decoder RTL.
module tb_http_chunked_body_decoder_top;
	import hcbd_pkg::*;

	localparam int SIZE_BITS = 32;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	hcbd_in_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	hcbd_out_t result;

	http_chunked_body_decoder_top #(.SIZE_BITS(SIZE_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#2000000;
		$display("tb_http_chunked_body_decoder_top: FAIL");
		$finish;
	end

	hcbd_in_t  pend_items[$];
	hcbd_out_t exp_results[$];
	int        fail_cnt = 0;
	int        n_sent = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        hold_req = 0;
	int        hold_seen = 0;
	int        hold_left = 0;
	bit        start_next = 1'b0;

	// decoder state as the testbench sees it
	hcbd_phase_t          dec_phase = PH_SIZE;
	logic [SIZE_BITS-1:0] dec_size = '0;
	logic                 dec_prev_cr = 1'b0;
	logic                 dec_has_content = 1'b0;
	logic                 dec_digits_seen = 1'b0;
	logic                 dec_digits_done = 1'b0;

	function automatic void note_result(hcbd_kind_t k, logic [7:0] b);
		hcbd_out_t r;
		r.out_kind = k;
		r.out_byte = b;
		exp_results.push_back(r);
	endfunction

	function automatic void clear_line();
		dec_has_content = 1'b0;
		dec_digits_seen = 1'b0;
		dec_digits_done = 1'b0;
	endfunction

	function automatic void framing_error();
		dec_phase = PH_ERROR;
		note_result(KIND_ERROR, 8'h00);
	endfunction

	function automatic void decode_byte(hcbd_in_t it);
		logic [7:0] c;
		logic       hv;
		logic [3:0] nib;
		c = it.in_byte;
		hv = 1'b1;
		nib = 4'd0;
		if (it.body_start) begin
			dec_phase = PH_SIZE;
			dec_size = '0;
			dec_prev_cr = 1'b0;
			clear_line();
		end
		if (c >= "0" && c <= "9") nib = 4'(c - "0");
		else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
		else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
		else hv = 1'b0;
		case (dec_phase)
			PH_SIZE: begin
				if (c == CH_LF && dec_prev_cr) begin
					if (!dec_has_content || !dec_digits_seen) begin
						framing_error();
					end else begin
						clear_line();
						dec_prev_cr = 1'b0;
						dec_phase = (dec_size == '0) ? PH_TRAILER : PH_DATA;
					end
				end else begin
					dec_prev_cr = (c == CH_CR);
					if (c != CH_CR) begin
						dec_has_content = 1'b1;
						if (!dec_digits_done) begin
							if (hv) begin
								if (dec_size[SIZE_BITS-1 -: 4] != 4'd0) begin
									framing_error();
								end else begin
									dec_size = {dec_size[SIZE_BITS-5:0], nib};
									dec_digits_seen = 1'b1;
								end
							end else if (dec_digits_seen || !(c == CH_SP || c == CH_TAB
									|| c == CH_LF || c == CH_VT || c == CH_FF)) begin
								dec_digits_done = 1'b1;
							end
						end
					end
				end
			end
			PH_DATA: begin
				dec_size = dec_size - 1'b1;
				if (dec_size == '0) dec_phase = PH_CR;
				note_result(KIND_DATA, c);
			end
			PH_CR: begin
				dec_prev_cr = (c == CH_CR);
				dec_phase = PH_LF;
			end
			PH_LF: begin
				if (c != CH_LF || !dec_prev_cr) begin
					framing_error();
				end else begin
					dec_size = '0;
					clear_line();
					dec_prev_cr = 1'b1;
					dec_phase = PH_SIZE;
				end
			end
			PH_TRAILER: begin
				if (c == CH_LF) begin
					if (!dec_has_content) begin
						dec_phase = PH_DONE;
						note_result(KIND_END, 8'h00);
					end else begin
						dec_has_content = 1'b0;
					end
				end else if (c != CH_SP && c != CH_TAB && c != CH_CR) begin
					dec_has_content = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	// driver: one transaction per accepted handshake, random gaps between them
	always @(posedge clk) begin
		logic v;
		if (arst_n) begin
			v = item_valid;
			if (item_valid && item_ready) begin
				decode_byte(item);
				v = 1'b0;
			end
			if (!v && pend_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				item <= pend_items.pop_front();
				v = 1'b1;
			end
			item_valid <= v;
		end
	end

	// monitor: checks results in order and drives result_ready
	always @(posedge clk) begin
		hcbd_out_t want;
		logic      rdy;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (exp_results.size() == 0) begin
					$display("%0t: unexpected result kind=%0d byte=%02h", $time,
						result.out_kind, result.out_byte);
					fail_cnt++;
				end else begin
					want = exp_results.pop_front();
					if (result.out_kind != want.out_kind) begin
						$display("%0t: out_kind expected %0d actual %0d", $time,
							want.out_kind, result.out_kind);
						fail_cnt++;
					end
					if (result.out_byte != want.out_byte) begin
						$display("%0t: out_byte expected %02h actual %02h", $time,
							want.out_byte, result.out_byte);
						fail_cnt++;
					end
				end
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = 600;
			end
			if (hold_left != 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				rdy = ($urandom_range(0, 99) >= recv_stall_pct);
			end
			result_ready <= rdy;
		end
	end

	task automatic push_byte(input logic [7:0] c);
		hcbd_in_t it;
		it.body_start = start_next;
		it.in_byte = c;
		start_next = 1'b0;
		pend_items.push_back(it);
		n_sent++;
	endtask

	task automatic crlf();
		push_byte(CH_CR);
		push_byte(CH_LF);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] ch;
		ch = (v < 4'd10) ? 8'(v) + "0" : 8'(v) - 8'd10 + "a";
		if (v >= 4'd10 && $urandom_range(0, 1)) ch = ch - 8'h20;
		return ch;
	endfunction

	// optional leading blanks and zeros, digits in mixed case, optional extension, CR LF
	task automatic size_line(input logic [31:0] n, input bit after_chunk);
		logic [7:0] blanks[5];
		string      s;
		blanks = '{CH_SP, CH_TAB, CH_VT, CH_FF, CH_LF};
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) push_byte(blanks[$urandom_range(0, after_chunk ? 3 : 4)]);
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_byte("0");
		s = $sformatf("%0h", n);
		for (int i = 0; i < s.len(); i++) push_byte(hex_char(4'(n >> (4 * (s.len() - 1 - i)))));
		case ($urandom_range(0, 5))
			0: begin
				push_byte(";");
				repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(8'h21, 8'h7e)));
			end
			1: push_byte(CH_LF);	// bare LF stays part of the line
			2: begin
				push_byte(" ");
				push_byte(CH_CR);	// stray CR is dropped
				push_text("x=1");
			end
			default: ;
		endcase
		crlf();
	endtask

	task automatic bad_closing();
		logic [7:0] ch;
		ch = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 2))
			0: begin
				push_byte(CH_CR);
				push_byte(ch == CH_LF ? 8'h00 : ch);
			end
			1: begin
				push_byte(ch == CH_CR ? 8'hff : ch);
				push_byte(CH_LF);
			end
			default: begin
				push_byte(CH_LF);
				push_byte(CH_CR);
			end
		endcase
	endtask

	task automatic good_body();
		int          nchunks;
		int          r;
		logic [31:0] n;
		start_next = 1'b1;
		nchunks = $urandom_range(0, 3);
		for (int i = 0; i < nchunks; i++) begin
			r = $urandom_range(0, 9);
			n = (r < 7) ? $urandom_range(1, 6) : (r < 9) ? $urandom_range(7, 40)
				: $urandom_range(41, 300);
			size_line(n, i != 0);
			repeat (n) push_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 19) == 0) begin
				bad_closing();
				return;
			end
			crlf();
		end
		size_line(32'd0, nchunks != 0);
		repeat ($urandom_range(0, 2)) begin
			push_text("X-t:");
			repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(8'h20, 8'h7e)));
			if ($urandom_range(0, 1)) push_byte(CH_CR);
			push_byte(CH_LF);
		end
		case ($urandom_range(0, 3))
			0: crlf();
			1: push_byte(CH_LF);
			2: begin
				push_byte(CH_SP);
				crlf();
			end
			default: begin
				push_byte(CH_TAB);
				push_byte(CH_SP);
				push_byte(CH_LF);
			end
		endcase
		// bytes after end of body are absorbed
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic broken_body();
		start_next = 1'b1;
		case ($urandom_range(0, 6))
			0: crlf();	// empty size line
			1: begin
				case ($urandom_range(0, 2))
					0: push_text("zz;q");
					1: push_text("  -5");
					default: push_text("x1F");
				endcase
				crlf();
			end
			2: begin	// size past 32 bits
				push_byte(hex_char(4'($urandom_range(1, 15))));
				repeat ($urandom_range(8, 9)) push_byte(hex_char(4'($urandom_range(0, 15))));
				crlf();
			end
			3: begin	// largest sizes, abandoned by the next body
				if ($urandom_range(0, 1)) push_text("FFFFFFFF");
				else repeat (8) push_byte(hex_char(4'($urandom_range(8, 15))));
				crlf();
				repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
			end
			4: begin	// LF right after a chunk's CR LF closes an empty line
				size_line(32'd1, 1'b0);
				push_byte(8'($urandom_range(0, 255)));
				crlf();
				push_byte(CH_LF);
			end
			5: begin	// truncated mid-data
				size_line($urandom_range(4, 20), 1'b0);
				repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
			end
			default: begin
				repeat ($urandom_range(1, 8)) begin
					start_next = ($urandom_range(0, 7) == 0);
					push_byte(8'($urandom_range(0, 255)));
				end
			end
		endcase
	endtask

	task automatic wait_drained();
		while (pend_items.size() != 0 || item_valid || exp_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int target;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: byte extremes, end of body, absorb after end, empty line,
		// missing digits, bad closing
		start_next = 1'b1;
		push_text("2");
		crlf();
		push_byte(8'h00);
		push_byte(8'hff);
		crlf();
		push_text("0");
		crlf();
		crlf();
		push_text("A");
		start_next = 1'b1;
		crlf();
		start_next = 1'b1;
		push_text("G");
		crlf();
		start_next = 1'b1;
		push_text("1");
		crlf();
		push_text("xx");
		push_byte(CH_LF);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					hold_req++;	// long receiver hold-off while items keep coming
				end
				1: begin
					send_idle_pct = 61;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 61;
				end
				default: begin
					send_idle_pct = 7;
					recv_stall_pct = 7;
				end
			endcase
			target = n_sent + 250;
			while (n_sent < target) begin
				if ($urandom_range(0, 99) < 75) good_body();
				else broken_body();
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (exp_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, exp_results.size());
			fail_cnt++;
		end
		if (fail_cnt == 0) begin
			$display("tb_http_chunked_body_decoder_top: PASS");
		end else begin
			$display("tb_http_chunked_body_decoder_top: FAIL");
		end
		$finish;
	end

endmodule
